@@ rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Entry layout, scan result bundle, operation codes and register constants.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 48;
	localparam int USED_W  = 5;
	localparam int CAP_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	// Operation codes carried by the mode field.
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// Register index decoded from the configuration address.
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             found;
		entry_t           found_entry;
		logic             best_seen;
		logic [KEY_W-1:0] best_key;
	} scan_res_t;

endpackage

@@ rtl/lfu_scan.sv @@
// ----------------------------------------------------------------------------
// lfu_scan: key match and victim search over a stream of table entries
// Entries arrive one per cycle from the table memory; the unit keeps the
// matching entry and the entry with the lowest count, oldest stamp first.
// ----------------------------------------------------------------------------
module lfu_scan import lfu_pkg::*; #(
	parameter int SLOT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              data_valid,
	input  logic [SLOT_W-1:0] data_idx,
	input  entry_t            data,
	input  logic [KEY_W-1:0]  key,
	output scan_res_t         res,
	output logic [SLOT_W-1:0] found_idx,
	output logic [SLOT_W-1:0] best_idx
);

	logic              found_q;
	logic              best_seen_q;
	logic [SLOT_W-1:0] found_idx_q;
	logic [SLOT_W-1:0] best_idx_q;
	entry_t            found_entry_q;
	entry_t            best_entry_q;
	logic              is_match;
	logic              is_better;

	assign is_match  = !found_q && (data.key == key);
	// Strictly lower, so the lowest slot wins among full ties.
	assign is_better = !best_seen_q ||
		({data.count, data.stamp} < {best_entry_q.count, best_entry_q.stamp});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_seen_q <= 1'b0;
		end else if (start) begin
			found_q     <= 1'b0;
			best_seen_q <= 1'b0;
		end else if (data_valid) begin
			if (is_match) begin
				found_q <= 1'b1;
			end
			best_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && is_match) begin
			found_idx_q   <= data_idx;
			found_entry_q <= data;
		end
		if (data_valid && is_better) begin
			best_idx_q   <= data_idx;
			best_entry_q <= data;
		end
	end

	assign res.found       = found_q;
	assign res.found_entry = found_entry_q;
	assign res.best_seen   = best_seen_q;
	assign res.best_key    = best_entry_q.key;
	assign found_idx       = found_idx_q;
	assign best_idx        = best_idx_q;

endmodule

@@ rtl/lfu_cache_table.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table: fully associative key/value cache with LFU replacement
// Get and put requests against a table of ENTRIES slots; evicts the least
// frequently used entry, least recently touched first among equal counts.
// ----------------------------------------------------------------------------
// Usage. A request (mode, key, value) enters on req_valid while req_stall is
// low; mode selects a get (lookup) or a put (insert or update). Each request
// gives exactly one response on rsp_valid: hit, read_value, evicted and
// evicted_key, held steady while rsp_stall is high.
// The single read port of the table memory sets the pace: the scan reads the
// occupied slots one per cycle, and the update state then writes back.
// Requests are handled one at a time; req_stall is high while one is in work.
// The next request is accepted while an earlier response still waits; its
// write-back then waits until that response is taken.
// Reset. Reset empties the table (the occupancy count goes to zero, so no
// slot memory clearing is needed), zeroes the touch clock and sets the
// capacity register to 16. Capacity must be written over the APB port only
// while idle; the user must keep to this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module lfu_cache_table import lfu_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request channel.
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                mode,
	input  logic [KEY_W-1:0]    key,
	input  logic [VALUE_W-1:0]  value,
	// Response channel.
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                hit,
	output logic [VALUE_W-1:0]  read_value,
	output logic                evicted,
	output logic [KEY_W-1:0]    evicted_key,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	// The occupancy never exceeds the largest capacity the register can hold.
	localparam int CAP_LIMIT = (ENTRIES > 31) ? 31 : ENTRIES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t              state_q;
	logic                mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [USED_W-1:0]   used_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [USED_W-1:0]   rd_cnt_q;
	logic                rd_valid_s1;
	logic [SLOT_W-1:0]   rd_idx_s1;
	entry_t              rd_data_s1;
	entry_t              entry_mem_q [ENTRIES];

	logic                rd_en;
	logic                scan_start;
	logic                scan_done;
	scan_res_t           scan_res;
	logic [SLOT_W-1:0]   found_idx;
	logic [SLOT_W-1:0]   best_idx;
	logic [CAP_W-1:0]    cap_eff;
	logic                cap_zero;
	logic                is_get;
	logic                do_touch;
	logic                do_insert;
	logic                do_evict;
	logic                commit;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_idx;
	entry_t              wr_entry;
	logic [COUNT_W-1:0]  touched_count;
	logic                cfg_write;

	// ------------------------------------------------------------------
	// Configuration port. Only the capacity register exists; pready is
	// tied high so every access completes in its access cycle.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : '0;

	// The usable capacity cannot exceed the number of physical slots.
	assign cap_eff  = (capacity_q > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : capacity_q;
	assign cap_zero = (cap_eff == '0);

	// ------------------------------------------------------------------
	// Table memory. Slots are always filled from index zero upward and an
	// evicted slot is refilled at once, so the occupied slots are exactly
	// 0 .. used_q-1 and the occupancy count stands in for valid bits.
	// Reads happen only in the scan and the single write only in the
	// update state, so the port never sees both on one entry at once.
	// ------------------------------------------------------------------
	assign rd_en      = (state_q == ST_SCAN) && (rd_cnt_q < used_q);
	assign scan_start = (state_q == ST_IDLE) && req_valid;
	// All reads issued and the last one consumed by the scan unit.
	assign scan_done  = (state_q == ST_SCAN) && (rd_cnt_q == used_q) && !rd_valid_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= entry_mem_q[SLOT_W'(rd_cnt_q)];
		end
		if (wr_en) begin
			entry_mem_q[wr_idx] <= wr_entry;
		end
		rd_idx_s1 <= SLOT_W'(rd_cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	lfu_scan #(
		.SLOT_W (SLOT_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.data_valid (rd_valid_s1),
		.data_idx   (rd_idx_s1),
		.data       (rd_data_s1),
		.key        (key_q),
		.res        (scan_res),
		.found_idx  (found_idx),
		.best_idx   (best_idx)
	);

	// ------------------------------------------------------------------
	// Update decision. A touch refreshes a present entry; an insert puts
	// a new key either into the victim's slot or into the next free one.
	// Nothing changes for a get miss or for a put with capacity zero.
	// ------------------------------------------------------------------
	assign is_get    = (mode_q == MODE_GET);
	assign do_touch  = scan_res.found && (is_get || !cap_zero);
	assign do_insert = !is_get && !cap_zero && !scan_res.found;
	// A nonzero capacity means a full table holds at least one entry.
	assign do_evict  = do_insert && (used_q >= cap_eff) && scan_res.best_seen;
	// The write-back waits until the response register is free.
	assign commit    = (state_q == ST_UPDATE) && !(rsp_valid && rsp_stall);
	assign wr_en     = commit && (do_touch || do_insert);

	assign touched_count = (scan_res.found_entry.count == COUNT_MAX) ?
		COUNT_MAX : scan_res.found_entry.count + COUNT_ONE;

	always_comb begin
		if (scan_res.found) begin
			wr_idx         = found_idx;
			wr_entry.key   = scan_res.found_entry.key;
			wr_entry.value = is_get ? scan_res.found_entry.value : value_q;
			wr_entry.count = touched_count;
		end else begin
			wr_idx         = do_evict ? best_idx : SLOT_W'(used_q);
			wr_entry.key   = key_q;
			wr_entry.value = value_q;
			wr_entry.count = COUNT_ONE;
		end
		wr_entry.stamp = clock_q;
	end

	// Touch clock and occupancy advance with the write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			used_q  <= '0;
		end else if (commit) begin
			if (do_touch || do_insert) begin
				clock_q <= clock_q + STAMP_W'(1);
			end
			if (do_insert && !do_evict) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer with the request capture and the response register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			mode_q      <= MODE_GET;
			key_q       <= '0;
			value_q     <= '0;
			rsp_valid   <= 1'b0;
			hit         <= 1'b0;
			read_value  <= '0;
			evicted     <= 1'b0;
			evicted_key <= '0;
		end else begin
			// A commit refills the response register in the cycle the old
			// response leaves, or while it is empty.
			if (commit) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						mode_q   <= mode;
						key_q    <= key;
						value_q  <= value;
						rd_cnt_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + USED_W'(1);
					end
					if (scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (commit) begin
						hit         <= scan_res.found;
						read_value  <= (is_get && scan_res.found) ?
							scan_res.found_entry.value : '0;
						evicted     <= do_evict;
						evicted_key <= do_evict ? scan_res.best_key : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= used_q))
		else $error("scan read counter ran past the occupancy");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> (used_q == $past(used_q) + USED_W'(1)))
		else $error("occupancy changed by other than one insert");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_UPDATE) && !rd_en)
		else $error("table write outside the update cycle");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && evicted) |-> (!hit && (read_value == '0)))
		else $error("eviction reported on a hit or with read data");

endmodule

@@ verif/tb_lfu_cache_table.sv @@
// ----------------------------------------------------------------------------
// tb_lfu_cache_table: self-checking testbench of the LFU cache table
// Drives get and put requests under random bursts and response stalls. Each
// response is checked against its typed row, if any, else against a cycle-free
// cache model with its own copy of the slots, use counts, stamps and capacity.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
	import lfu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 16;
	// Cycles with no request and no response taken before the run is abandoned.
	// The longest correct quiet stretch is the deliberate receiver hold-off.
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 100;
	localparam int SETTLE_CYCLES = 30;
	localparam logic [2:0] CAPACITY_ADDR = 3'(4 * REG_CAPACITY);

	// One response of the block, field by field.
	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} cache_result_t;

	// Rows of the directed part: a capacity write, a request checked against the
	// cache model, or a request whose response is written out in the row itself.
	typedef enum logic [1:0] {ROW_CFG, ROW_RUN, ROW_TYPED} row_kind_e;

	typedef struct packed {
		row_kind_e          kind;
		logic [CAP_W-1:0]   cap;
		logic               op;
		logic [KEY_W-1:0]   k;
		logic [VALUE_W-1:0] v;
		cache_result_t      want;
	} dir_row_t;

	localparam cache_result_t ALL_ZERO = '0;

	// The directed part starts with a two-entry table so that the tie break
	// (equal counts, older touch goes first) and the lower-count victim can be
	// read off by hand. Capacity zero then shows that puts are ignored while a
	// present key still reports a hit. Capacity 31 saturates at sixteen, and
	// capacity 1 with four entries held shows the table shrinking no further.
	localparam dir_row_t DIRECTED [28] = '{
		'{ROW_CFG,   5'd2,  MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h1,        32'h11,
			'{1'b0, 32'h0, 1'b1, 32'h0}},
		'{ROW_TYPED, 5'd0,  MODE_GET, 32'hFFFFFFFF, 32'h0,
			'{1'b1, 32'hFFFFFFFF, 1'b0, 32'h0}},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h2,        32'h22,
			'{1'b0, 32'h0, 1'b1, 32'h1}},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'hFFFFFFFF, 32'h0,
			'{1'b1, 32'h0, 1'b0, 32'h0}},
		'{ROW_TYPED, 5'd0,  MODE_GET, 32'h1,        32'h0,        ALL_ZERO},
		'{ROW_CFG,   5'd0,  MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h3,        32'h3,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h2,        32'h99,
			'{1'b1, 32'h0, 1'b0, 32'h0}},
		'{ROW_TYPED, 5'd0,  MODE_GET, 32'h2,        32'h0,
			'{1'b1, 32'h22, 1'b0, 32'h0}},
		'{ROW_TYPED, 5'd0,  MODE_GET, 32'h3,        32'h0,        ALL_ZERO},
		'{ROW_CFG,   5'd31, MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_TYPED, 5'd0,  MODE_PUT, 32'h4,        32'h44,       ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_PUT, 32'h5,        32'h5555AAAA, ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_GET, 32'h4,        32'h0,        ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_GET, 32'hFFFFFFFF, 32'h0,        ALL_ZERO},
		'{ROW_CFG,   5'd1,  MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_PUT, 32'h6,        32'h66,       ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_PUT, 32'h7,        32'h77,       ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_PUT, 32'h7,        32'h78,       ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_GET, 32'h6,        32'h0,        ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_GET, 32'h7,        32'h0,        ALL_ZERO},
		'{ROW_CFG,   5'd16, MODE_GET, 32'h0,        32'h0,        ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_PUT, 32'h8,        32'h88,       ALL_ZERO},
		'{ROW_RUN,   5'd0,  MODE_GET, 32'hFFFFFFFF, 32'h0,        ALL_ZERO}
	};

	// Capacity of each random phase. Zero keeps the previous key pool so that
	// gets still find something while every put is ignored.
	localparam logic [CAP_W-1:0] PHASE_CAPS [9] = '{
		5'd16, 5'd3, 5'd0, 5'd17, 5'd1, 5'd8, 5'd31, 5'd16, 5'd6
	};

	// Every input is known from time zero.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               mode = MODE_GET;
	logic [KEY_W-1:0]   key = '0;
	logic [VALUE_W-1:0] value = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               hit;
	logic [VALUE_W-1:0] read_value;
	logic               evicted;
	logic [KEY_W-1:0]   evicted_key;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	lfu_cache_table #(
		.ENTRIES(TABLE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.evicted_key(evicted_key),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Cache model. Its state mirrors the block after reset: no valid slot, an
	// empty occupancy count, the touch clock at zero and capacity sixteen.
	// ------------------------------------------------------------------------
	bit                 slot_valid [TABLE_SLOTS];
	logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
	logic [VALUE_W-1:0] slot_value [TABLE_SLOTS];
	logic [COUNT_W-1:0] slot_count [TABLE_SLOTS];
	logic [STAMP_W-1:0] slot_stamp [TABLE_SLOTS];
	int                 slots_used = 0;
	logic [STAMP_W-1:0] touch_clock = '0;
	logic [CAP_W-1:0]   capacity_setting = CAPACITY_RESET;

	cache_result_t expected_results [$];
	int            mismatches = 0;
	int            responses_seen = 0;
	int            burst_left = 0;
	bit            hold_off_req = 1'b0;
	logic [KEY_W-1:0] key_pool [$];

	// A touch raises the use count (it saturates) and stamps the slot with the
	// current touch clock, which then moves on.
	function automatic void touch_slot(int s);
		if (slot_count[s] != COUNT_MAX) begin
			slot_count[s] = slot_count[s] + COUNT_ONE;
		end
		slot_stamp[s] = touch_clock;
		touch_clock = touch_clock + STAMP_W'(1);
	endfunction

	// Applies one request to the model and returns the response it must give.
	function automatic cache_result_t predict_access(logic op, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v);
		cache_result_t r;
		int found;
		int victim;
		int dst;
		int eff_cap;
		r = '0;
		found = -1;
		victim = -1;
		dst = -1;
		eff_cap = (capacity_setting > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity_setting);
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (found < 0 && slot_valid[i] && slot_key[i] == k) begin
				found = i;
			end
		end
		r.hit = (found >= 0);
		if (op == MODE_GET) begin
			if (found >= 0) begin
				r.read_value = slot_value[found];
				touch_slot(found);
			end
		end else if (eff_cap != 0) begin
			if (found >= 0) begin
				slot_value[found] = v;
				touch_slot(found);
			end else begin
				// Victim: lowest count, then oldest stamp, then lowest slot.
				if (slots_used >= eff_cap) begin
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (slot_valid[i] && (victim < 0 ||
								slot_count[i] < slot_count[victim] ||
								(slot_count[i] == slot_count[victim] &&
								slot_stamp[i] < slot_stamp[victim]))) begin
							victim = i;
						end
					end
					if (victim >= 0) begin
						r.evicted = 1'b1;
						r.evicted_key = slot_key[victim];
						slot_valid[victim] = 1'b0;
						slots_used--;
						dst = victim;
					end
				end
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (dst < 0 && !slot_valid[i]) begin
						dst = i;
					end
				end
				if (dst >= 0) begin
					slot_valid[dst] = 1'b1;
					slot_key[dst] = k;
					slot_value[dst] = v;
					slot_count[dst] = COUNT_ONE;
					slot_stamp[dst] = touch_clock;
					touch_clock = touch_clock + STAMP_W'(1);
					slots_used++;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH response %0d %s: got %h, expected %h",
			responses_seen, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Request side. Requests go out in bursts of random length; between bursts
	// valid drops for a random gap, sometimes none at all. A request is held
	// until the block takes it, and only then is it applied to the model.
	// ------------------------------------------------------------------------
	task automatic drive_request(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
			bit typed, cache_result_t typed_want);
		int gap;
		cache_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_valid <= 1'b1;
		mode <= op;
		key <= k;
		value <= v;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = predict_access(op, k, v);
		expected_results.push_back(typed ? typed_want : predicted);
	endtask

	// Stops offering requests until every response is in and the block has
	// dropped its stall, so that nothing is still in work.
	task automatic wait_idle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0 || req_stall) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycles until pready. The
	// register takes the write, or prdata is sampled, at the final edge.
	task automatic apb_transfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Capacity changes only while the block is idle. The value is read back
	// after the write and the model takes the new setting.
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		logic [31:0] readback;
		wait_idle();
		apb_transfer(1'b1, CAPACITY_ADDR, 32'(cap), readback);
		apb_transfer(1'b0, CAPACITY_ADDR, '0, readback);
		if (readback[CAP_W-1:0] !== cap) begin
			report_mismatch("capacity readback", 32'(readback[CAP_W-1:0]), 32'(cap));
		end
		capacity_setting = cap;
	endtask

	// ------------------------------------------------------------------------
	// Response side. The receiver stalls in runs of a randomly chosen style:
	// never, half the time, mostly, or on a fixed period. When asked, it holds
	// off for a long stretch so the block fills up and stalls its requests.
	// ------------------------------------------------------------------------
	initial begin
		int run_left;
		int style;
		int tick;
		run_left = 0;
		style = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_off_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (run_left == 0) begin
					style = $urandom_range(0, 3);
					run_left = $urandom_range(5, 60);
				end
				run_left--;
				case (style)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	// Each response taken is compared with the oldest expectation. Outputs are
	// sampled at the edge, before any update of that edge takes effect.
	always @(posedge clk) begin
		cache_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("with no request waiting, rsp_valid", 32'(rsp_valid), 32'h0);
			end else begin
				want = expected_results.pop_front();
				if (hit !== want.hit) begin
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				end
				if (read_value !== want.read_value) begin
					report_mismatch("read_value", read_value, want.read_value);
				end
				if (evicted !== want.evicted) begin
					report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
				end
				if (evicted_key !== want.evicted_key) begin
					report_mismatch("evicted_key", evicted_key, want.evicted_key);
				end
			end
			responses_seen++;
		end
	end

	// Watchdog: a long stretch with neither a request nor a response taken
	// means the block has hung.
	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, the directed table, then random phases over a
	// range of capacities, then drain and report.
	// ------------------------------------------------------------------------
	initial begin
		dir_row_t row;
		int pool_size;
		int pick;
		logic op;
		logic [KEY_W-1:0] k;
		logic [VALUE_W-1:0] v;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				set_capacity(row.cap);
			end else begin
				drive_request(row.op, row.k, row.v, row.kind == ROW_TYPED, row.want);
			end
		end

		// Keys mostly come from a small pool so that gets hit and puts collide;
		// a pool larger than the capacity forces a steady stream of evictions.
		// Now and then a fully random key misses.
		foreach (PHASE_CAPS[p]) begin
			set_capacity(PHASE_CAPS[p]);
			if (PHASE_CAPS[p] != 0 || key_pool.size() == 0) begin
				key_pool.delete();
				pool_size = $urandom_range(2, 24);
				for (int j = 0; j < pool_size; j++) begin
					pick = $urandom_range(0, 9);
					key_pool.push_back(pick == 0 ? '0 : pick == 1 ? '1 : KEY_W'($urandom));
				end
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Long receiver hold-off in a small table while requests keep coming.
				if (p == 1 && n == 15) begin
					hold_off_req = 1'b1;
				end
				// Once, the sender waits for every response before going on.
				if (p == 4 && n == 50) begin
					wait_idle();
				end
				op = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 6) == 0) begin
					k = KEY_W'($urandom);
				end else begin
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				end
				v = VALUE_W'($urandom);
				drive_request(op, k, v, 1'b0, ALL_ZERO);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
